>>> hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is held
`define TESQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tesq assertion failed");

// concurrent check that also holds across reset
`define TESQ_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tesq reset assertion failed");

`endif

>>> hw/rtl/tesq_pkg.sv
// shared types and constants of the timed event queue scheduler
package tesq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // request codes
  typedef logic [2:0] req_t;
  localparam req_t REQ_ADD     = 3'd0;
  localparam req_t REQ_TICK    = 3'd1;
  localparam req_t REQ_SERVICE = 3'd2;
  localparam req_t REQ_CLEAR   = 3'd3;
  localparam req_t REQ_RST_TIME = 3'd4;
  localparam req_t REQ_DRAW    = 3'd5;

  // configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DEFERRED = 1'b0;
  localparam cfg_idx_t CFG_DRAW_EN  = 1'b1;

  // one queued event
  typedef struct packed {
    logic [31:0] due;
    logic [31:0] period;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [1:0]  kind;
    logic [15:0] handle;
  } entry_t;

  // captured request
  typedef struct packed {
    req_t   req_type;
    entry_t item;
  } req_item_t;

  // one result
  typedef struct packed {
    logic        draw_valid;
    logic [15:0] handle;
    logic [1:0]  kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] due;
    logic        status;
    logic [31:0] current_time;
  } result_t;

  // command broadcast to every cell of the queue
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   item;
  } cell_cmd_t;

endpackage

>>> hw/rtl/tesq_ifs.sv
// valid/ready channel interfaces of the timed event queue scheduler

// request channel
interface tesq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] due_time;
  logic [31:0] repeat_period;
  logic [1:0]  figure_kind;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [15:0] figure_handle;

  modport source (output valid, req_type, due_time, repeat_period, figure_kind,
                  pos_x, pos_y, figure_handle, input ready);
  modport sink (input valid, req_type, due_time, repeat_period, figure_kind,
                pos_x, pos_y, figure_handle, output ready);
endinterface

// result channel
interface tesq_res_if;
  logic        valid;
  logic        ready;
  logic        draw_valid;
  logic [15:0] out_handle;
  logic [1:0]  out_kind;
  logic [7:0]  out_x;
  logic [7:0]  out_y;
  logic [31:0] out_due;
  logic        status;
  logic [31:0] current_time;

  modport source (output valid, draw_valid, out_handle, out_kind, out_x, out_y,
                  out_due, status, current_time, input ready);
  modport sink (input valid, draw_valid, out_handle, out_kind, out_x, out_y,
                out_due, status, current_time, output ready);
endinterface

// configuration write channel
interface tesq_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/timed_event_queue_scheduler.sv
// top level of the timed event queue scheduler
//
// Requests enter on in_req (valid/ready): add, tick, service pending, clear all,
// reset time and draw now. Every request gives exactly one transaction on
// out_res carrying draw data, the add status and the time after the request.
// cfg_wr sets the deferred mode and draw enable bits; it is always ready.
// The user must see that it is written only while the block is idle; the
// block itself does not enforce this. Events sit in a row of QUEUE_DEPTH
// cells kept sorted by due time; an insert shifts the cells behind the new
// event, and a head removal shifts every cell toward the head. A request is
// captured in the request register and executed in the execute state, which
// writes its result to the output register. A dispatch whose event repeats
// passes through a re-arm state that re-inserts it before the next request
// is taken. The output register lets the next request in while a result
// waits; a stalled receiver holds the execute state until the register is free.
// Reset (synchronous, active low) empties the queue, zeroes the time counter,
// the pending flag and both configuration bits, and drops any waiting result.
module timed_event_queue_scheduler
  import tesq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  tesq_req_if.sink   in_req,
  tesq_res_if.source out_res,
  tesq_cfg_if.sink   cfg_wr
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REARM
  } state_t;

  state_t           state_r, state_nxt;
  req_item_t        req_r, req_nxt;
  entry_t           rearm_r, rearm_nxt;
  result_t          res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      time_r, time_nxt;
  logic             pending_r, pending_nxt;
  logic             deferred_r, deferred_nxt;
  logic             draw_en_r, draw_en_nxt;

  cell_cmd_t   cmd;
  entry_t      head;
  logic        slot_free;
  logic [31:0] time_inc;
  logic [31:0] time_cmp;
  logic        head_due;
  logic        add_ok;
  logic        dispatch;

  // sorted queue
  tesq_chain u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .count (count_r),
    .head  (head)
  );

  // handshake outputs
  assign in_req.ready  = (state_r == S_IDLE);
  assign cfg_wr.ready  = 1'b1;
  assign out_res.valid = out_valid_r;
  assign out_res.draw_valid   = res_r.draw_valid;
  assign out_res.out_handle   = res_r.handle;
  assign out_res.out_kind     = res_r.kind;
  assign out_res.out_x        = res_r.x;
  assign out_res.out_y        = res_r.y;
  assign out_res.out_due      = res_r.due;
  assign out_res.status       = res_r.status;
  assign out_res.current_time = res_r.current_time;

  // request decode helpers
  assign slot_free = !out_valid_r || out_res.ready;
  assign time_inc  = time_r + 32'd1;
  assign time_cmp  = (req_r.req_type == REQ_TICK) ? time_inc : time_r;
  assign head_due  = (count_r != '0) && draw_en_r && (head.due < time_cmp);
  assign add_ok    = (req_r.item.due != 32'd0) && (count_r != CNT_W'(QUEUE_DEPTH));
  assign dispatch  = ((req_r.req_type == REQ_TICK) && head_due && !deferred_r) ||
                     ((req_r.req_type == REQ_SERVICE) && pending_r && deferred_r &&
                      head_due);

  // queue command
  always_comb begin
    cmd.op   = CELL_HOLD;
    cmd.item = req_r.item;
    if ((state_r == S_EXEC) && slot_free) begin
      if ((req_r.req_type == REQ_ADD) && add_ok) begin
        cmd.op = CELL_INSERT;
      end else if (dispatch) begin
        cmd.op = CELL_POP;
      end
    end else if ((state_r == S_REARM) && (rearm_r.due != 32'd0)) begin
      cmd.op   = CELL_INSERT;
      cmd.item = rearm_r;
    end
  end

  // next state and result
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    rearm_nxt     = rearm_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    count_nxt     = count_r;
    time_nxt      = time_r;
    pending_nxt   = pending_r;
    deferred_nxt  = deferred_r;
    draw_en_nxt   = draw_en_r;

    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    // configuration writes
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_DEFERRED: deferred_nxt = cfg_wr.data;
        CFG_DRAW_EN:  draw_en_nxt  = cfg_wr.data;
        default:      ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          req_nxt.req_type    = in_req.req_type;
          req_nxt.item.due    = in_req.due_time;
          req_nxt.item.period = in_req.repeat_period;
          req_nxt.item.x      = in_req.pos_x;
          req_nxt.item.y      = in_req.pos_y;
          req_nxt.item.kind   = in_req.figure_kind;
          req_nxt.item.handle = in_req.figure_handle;
          state_nxt           = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          res_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          unique case (req_r.req_type)
            REQ_ADD: begin
              if (add_ok) begin
                count_nxt = count_r + CNT_W'(1);
              end else begin
                res_nxt.status = 1'b1;
              end
            end
            REQ_TICK: begin
              time_nxt = time_inc;
              if (head_due && deferred_r) begin
                pending_nxt = 1'b1;
              end
            end
            REQ_SERVICE:  pending_nxt = 1'b0;
            REQ_CLEAR:    count_nxt   = '0;
            REQ_RST_TIME: time_nxt    = 32'd0;
            REQ_DRAW: begin
              if (draw_en_r) begin
                res_nxt.draw_valid = 1'b1;
                res_nxt.handle     = req_r.item.handle;
                res_nxt.kind       = req_r.item.kind;
                res_nxt.x          = req_r.item.x;
                res_nxt.y          = req_r.item.y;
                res_nxt.due        = req_r.item.due;
              end
            end
            default: ;
          endcase
          // head dispatch with optional re-arm
          if (dispatch) begin
            res_nxt.draw_valid = 1'b1;
            res_nxt.handle     = head.handle;
            res_nxt.kind       = head.kind;
            res_nxt.x          = head.x;
            res_nxt.y          = head.y;
            res_nxt.due        = head.due;
            count_nxt          = count_r - CNT_W'(1);
            rearm_nxt          = head;
            rearm_nxt.due      = head.due + head.period;
            if (head.period != 32'd0) begin
              state_nxt = S_REARM;
            end
          end
          res_nxt.current_time = time_nxt;
        end
      end
      S_REARM: begin
        if (rearm_r.due != 32'd0) begin
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      time_r      <= 32'd0;
      pending_r   <= 1'b0;
      deferred_r  <= 1'b0;
      draw_en_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      time_r      <= time_nxt;
      pending_r   <= pending_nxt;
      deferred_r  <= deferred_nxt;
      draw_en_r   <= draw_en_nxt;
    end
    req_r   <= req_nxt;
    rearm_r <= rearm_nxt;
    res_r   <= res_nxt;
  end

endmodule

>>> hw/rtl/tesq_cell.sv
// one slot of the sorted shift-register queue
module tesq_cell
  import tesq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  entry_t    left_entry,
  input  logic      left_keep,
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      keep
);

  entry_t entry_r;
  entry_t entry_nxt;

  // slot stays put on insert when it is in use and not later than the new event
  assign keep  = occupied && (entry_r.due <= cmd.item.due);
  assign entry = entry_r;

  // next slot contents
  always_comb begin
    case (cmd.op)
      CELL_INSERT: begin
        if (keep) begin
          entry_nxt = entry_r;
        end else if (left_keep) begin
          entry_nxt = cmd.item;
        end else begin
          entry_nxt = left_entry;
        end
      end
      CELL_POP: entry_nxt = right_entry;
      default:  entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> hw/rtl/tesq_chain.sv
// row of queue cells, head at cell zero
module tesq_chain
  import tesq_pkg::*;
(
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [CNT_W-1:0] count,
  output entry_t           head
);

  entry_t                 cell_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep;

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      entry_t left_e;
      entry_t right_e;
      logic   left_k;

      // neighbor hookup, the ends see the command item
      if (gi == 0) begin : g_first
        assign left_e = cmd.item;
        assign left_k = 1'b1;
      end else begin : g_mid
        assign left_e = cell_q[gi-1];
        assign left_k = keep[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign right_e = cmd.item;
      end else begin : g_inner
        assign right_e = cell_q[gi+1];
      end

      tesq_cell u_cell (
        .clk         (clk),
        .cmd         (cmd),
        .occupied    (count > CNT_W'(gi)),
        .left_entry  (left_e),
        .left_keep   (left_k),
        .right_entry (right_e),
        .entry       (cell_q[gi]),
        .keep        (keep[gi])
      );
    end
  endgenerate

  assign head = cell_q[0];

endmodule

>>> hw/rtl/tesq_checker.sv
// port-level checks of the timed event queue scheduler and their binding
`include "assert_macros.svh"

module tesq_port_checker
  import tesq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        draw_valid,
  input logic        status,
  input logic [15:0] out_handle,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_x,
  input logic [7:0]  out_y,
  input logic [31:0] out_due
);

  logic fields_zero;

  // all draw fields cleared
  assign fields_zero = (out_handle == 16'd0) && (out_kind == 2'd0) && (out_x == 8'd0) &&
                       (out_y == 8'd0) && (out_due == 32'd0);

  // a stalled result transaction is not withdrawn
  `TESQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)

  // a rejected add never carries a draw
  `TESQ_ASSERT(a_status_no_draw, clk, rst_n, out_valid |-> !(status && draw_valid))

  // draw fields are zero when nothing is drawn
  `TESQ_ASSERT(a_idle_fields, clk, rst_n, out_valid && !draw_valid |-> fields_zero)

  // reset drops any waiting result
  `TESQ_ASSERT_NR(a_rst_empty, clk, !rst_n |=> !out_valid)

endmodule

bind timed_event_queue_scheduler tesq_port_checker u_tesq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .draw_valid (out_res.draw_valid),
  .status     (out_res.status),
  .out_handle (out_res.out_handle),
  .out_kind   (out_res.out_kind),
  .out_x      (out_res.out_x),
  .out_y      (out_res.out_y),
  .out_due    (out_res.out_due)
);
